// ===== sv/lrat_pkg.sv =====
// ----------------------------------------------------------------------------
// lrat_pkg
// shared sizes, action and status codes, and controller/datapath interfaces
// of the line retention age tracker
// ----------------------------------------------------------------------------
package lrat_pkg;

  // table geometry
  localparam int LINE_BYTES       = 64;
  localparam int LINE_SHIFT       = 6;
  localparam int BUFFER_SLOTS     = 16;
  localparam int LINES_PER_BUFFER = 64;
  localparam int SLOT_W           = 4;
  localparam int LINE_W           = 6;
  localparam int ADDR_W           = SLOT_W + LINE_W;
  localparam int STAMP_DEPTH      = BUFFER_SLOTS * LINES_PER_BUFFER;

  // field widths
  localparam int ACTION_W = 3;
  localparam int BYTES_W  = 13;
  localparam int CYC_W    = 32;
  localparam int STEP_W   = 16;
  localparam int COUNT_W  = 64;
  localparam int STATUS_W = 2;
  localparam int NLINE_W  = 7;
  localparam int CFG_IDX_W = 1;

  // largest allocation in bytes, one bit wider than the size field
  localparam logic [BYTES_W:0] BUFFER_BYTES = (BYTES_W + 1)'(LINES_PER_BUFFER * LINE_BYTES);

  // actions
  localparam logic [ACTION_W-1:0] ACT_ALLOCATE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ACCESS   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_COMPUTE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SIZE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_STEP  = 1'd1;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request
    logic eval;   // decode, bounds checks, cost product
    logic check;  // overflow check and commit
    logic walk;   // one line of the walk
  } lrat_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk_go;    // the request walks lines
    logic walk_read;  // the walk is a read walk
    logic walk_last;  // current walk line is the last one
  } lrat_sts_t;

endpackage

// ===== sv/line_retention_age_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// line_retention_age_tracker_unit
// running cycle count with per-line write stamps and per-slot largest read age
//
//   channel   handshake            payload
//   request   start / busy         action, buffer_slot, size_bytes,
//                                  offset_bytes, is_write, compute_amount
//   result    done (one cycle)     status, max_age, cycle_now
//   config    cfg_we               cfg_index, cfg_wdata
//
// the result follows the decode and check states, then, for an allocate or access that
// passes its checks, the line walk over its lines, one stamp per cycle, and for a read
// access the read and age drain states. busy stays high until the result cycle
// ends, so a new request is taken only after the last result has been given.
// reset clears the counter, live flags and largest ages at once; stamp memory
// needs no clearing. the result receiver cannot stall.
// ----------------------------------------------------------------------------
module line_retention_age_tracker_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [lrat_pkg::ACTION_W-1:0]         action,
  input  logic [lrat_pkg::SLOT_W-1:0]           buffer_slot,
  input  logic [lrat_pkg::BYTES_W-1:0]          size_bytes,
  input  logic [lrat_pkg::BYTES_W-1:0]          offset_bytes,
  input  logic                                  is_write,
  input  logic [lrat_pkg::CYC_W-1:0]            compute_amount,
  input  logic                                  cfg_we,
  input  logic [lrat_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lrat_pkg::STEP_W-1:0]           cfg_wdata,
  output logic                                  done,
  output logic [lrat_pkg::STATUS_W-1:0]         status,
  output logic [lrat_pkg::COUNT_W-1:0]          max_age,
  output logic [lrat_pkg::COUNT_W-1:0]          cycle_now
);

  lrat_pkg::lrat_cmd_t cmd;
  lrat_pkg::lrat_sts_t sts;

  // sequencer
  lrat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath
  lrat_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .buffer_slot    (buffer_slot),
    .size_bytes     (size_bytes),
    .offset_bytes   (offset_bytes),
    .is_write       (is_write),
    .compute_amount (compute_amount),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .status         (status),
    .max_age        (max_age),
    .cycle_now      (cycle_now)
  );

endmodule

// ===== sv/lrat_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrat_ctrl
// sequencer of the tracker: capture, decode, check, line walk, read drain, result
// ----------------------------------------------------------------------------
module lrat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lrat_pkg::lrat_sts_t sts,
  output lrat_pkg::lrat_cmd_t cmd,
  output logic               busy,
  output logic               done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DRAIN_RD  = 3'd4;
  localparam logic [2:0] S_DRAIN_AGE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.walk_go ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_next = sts.walk_read ? S_DRAIN_RD : S_DONE;
        end
      end
      S_DRAIN_RD:  state_next = S_DRAIN_AGE;
      S_DRAIN_AGE: state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== sv/lrat_datapath.sv =====
// ----------------------------------------------------------------------------
// lrat_datapath
// cycle counter, slot table, line stamp memory and read age pipeline
// ----------------------------------------------------------------------------
module lrat_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lrat_pkg::lrat_cmd_t                   cmd,
  output lrat_pkg::lrat_sts_t                   sts,
  input  logic [lrat_pkg::ACTION_W-1:0]         action,
  input  logic [lrat_pkg::SLOT_W-1:0]           buffer_slot,
  input  logic [lrat_pkg::BYTES_W-1:0]          size_bytes,
  input  logic [lrat_pkg::BYTES_W-1:0]          offset_bytes,
  input  logic                                  is_write,
  input  logic [lrat_pkg::CYC_W-1:0]            compute_amount,
  input  logic                                  cfg_we,
  input  logic [lrat_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lrat_pkg::STEP_W-1:0]           cfg_wdata,
  output logic [lrat_pkg::STATUS_W-1:0]         status,
  output logic [lrat_pkg::COUNT_W-1:0]          max_age,
  output logic [lrat_pkg::COUNT_W-1:0]          cycle_now
);

  localparam int BW = lrat_pkg::BYTES_W;

  // configuration
  logic [lrat_pkg::STEP_W-1:0] write_step;
  logic [lrat_pkg::STEP_W-1:0] read_step;

  // captured request
  logic [lrat_pkg::ACTION_W-1:0] act_q;
  logic [lrat_pkg::SLOT_W-1:0]   slot_q;
  logic [BW-1:0]                 size_q;
  logic [BW-1:0]                 off_q;
  logic                          wr_q;
  logic [lrat_pkg::CYC_W-1:0]    cyc_q;

  // block state
  logic [lrat_pkg::COUNT_W-1:0]  count;
  logic [lrat_pkg::BUFFER_SLOTS-1:0] live;
  logic [BW-1:0]                 slot_size [lrat_pkg::BUFFER_SLOTS];
  logic [lrat_pkg::COUNT_W-1:0]  slot_max  [lrat_pkg::BUFFER_SLOTS];
  logic [lrat_pkg::COUNT_W-1:0]  stamp_mem [lrat_pkg::STAMP_DEPTH];

  // check and walk registers
  logic [lrat_pkg::STATUS_W-1:0] pre_q;
  logic [lrat_pkg::STATUS_W-1:0] status_q;
  logic [lrat_pkg::NLINE_W-1:0]  remain_q;
  logic [lrat_pkg::LINE_W-1:0]   line_q;
  logic [lrat_pkg::CYC_W-1:0]    add_q;

  // read age pipeline
  logic                          rd_v;
  logic                          age_v;
  logic [lrat_pkg::COUNT_W-1:0]  rdata;
  logic [lrat_pkg::COUNT_W-1:0]  age;

  // decode signals
  logic                          size_zero;
  logic                          size_big;
  logic [BW:0]                   end_bytes;
  logic                          out_of_bounds;
  logic [lrat_pkg::NLINE_W-1:0]  alloc_lines;
  logic [lrat_pkg::NLINE_W:0]    first_line;
  logic [lrat_pkg::NLINE_W:0]    last_line;
  logic [lrat_pkg::NLINE_W-1:0]  acc_lines;
  logic [lrat_pkg::STATUS_W-1:0] pre_next;
  logic [lrat_pkg::NLINE_W-1:0]  lines_next;
  logic [lrat_pkg::LINE_W-1:0]   first_next;
  logic [lrat_pkg::STEP_W-1:0]   step_sel;
  logic [lrat_pkg::NLINE_W+lrat_pkg::STEP_W-1:0] cost;
  logic [lrat_pkg::CYC_W-1:0]    add_next;

  // check signals
  logic [lrat_pkg::COUNT_W:0]    sum;
  logic [lrat_pkg::STATUS_W-1:0] fin;
  logic                          walk_read;
  logic [lrat_pkg::ADDR_W-1:0]   addr;
  logic [lrat_pkg::COUNT_W-1:0]  wcount;

  // request decode and bounds
  always_comb begin
    size_zero     = (size_q == '0);
    size_big      = ({1'b0, size_q} > lrat_pkg::BUFFER_BYTES);
    end_bytes     = {1'b0, off_q} + {1'b0, size_q};
    out_of_bounds = !live[slot_q] || (end_bytes > {1'b0, slot_size[slot_q]});
    alloc_lines   = lrat_pkg::NLINE_W'(({1'b0, size_q} + (BW + 1)'(lrat_pkg::LINE_BYTES - 1))
                    >> lrat_pkg::LINE_SHIFT);
    first_line    = (lrat_pkg::NLINE_W + 1)'(off_q >> lrat_pkg::LINE_SHIFT);
    last_line     = (lrat_pkg::NLINE_W + 1)'((end_bytes - (BW + 1)'(1)) >> lrat_pkg::LINE_SHIFT);
    acc_lines     = lrat_pkg::NLINE_W'(last_line - first_line + (lrat_pkg::NLINE_W + 1)'(1));
    pre_next      = lrat_pkg::ST_OK;
    lines_next    = '0;
    first_next    = '0;
    step_sel      = '0;
    case (act_q)
      lrat_pkg::ACT_ALLOCATE: begin
        pre_next   = (size_zero || size_big) ? lrat_pkg::ST_SIZE : lrat_pkg::ST_OK;
        lines_next = alloc_lines;
        step_sel   = write_step;
      end
      lrat_pkg::ACT_ACCESS: begin
        if (size_zero) begin
          pre_next = lrat_pkg::ST_SIZE;
        end else if (out_of_bounds) begin
          pre_next = lrat_pkg::ST_INVALID;
        end
        lines_next = acc_lines;
        first_next = lrat_pkg::LINE_W'(first_line);
        step_sel   = wr_q ? write_step : read_step;
      end
      lrat_pkg::ACT_FREE: begin
        pre_next = live[slot_q] ? lrat_pkg::ST_OK : lrat_pkg::ST_INVALID;
      end
      default: ;
    endcase
    cost = lines_next * step_sel;
    if (act_q == lrat_pkg::ACT_COMPUTE) begin
      add_next = cyc_q;
    end else if (act_q == lrat_pkg::ACT_ALLOCATE || act_q == lrat_pkg::ACT_ACCESS) begin
      add_next = lrat_pkg::CYC_W'(cost);
    end else begin
      add_next = '0;
    end
  end

  // overflow check and final status
  always_comb begin
    sum = {1'b0, count} + (lrat_pkg::COUNT_W + 1)'(add_q);
    if (pre_q != lrat_pkg::ST_OK) begin
      fin = pre_q;
    end else if (sum[lrat_pkg::COUNT_W]) begin
      fin = lrat_pkg::ST_OVERFLOW;
    end else begin
      fin = lrat_pkg::ST_OK;
    end
    walk_read     = (act_q == lrat_pkg::ACT_ACCESS) && !wr_q;
    sts.walk_go   = (fin == lrat_pkg::ST_OK) &&
                    (act_q == lrat_pkg::ACT_ALLOCATE || act_q == lrat_pkg::ACT_ACCESS);
    sts.walk_read = walk_read;
    sts.walk_last = (remain_q == lrat_pkg::NLINE_W'(1));
    addr          = {slot_q, line_q};
    wcount        = count + lrat_pkg::COUNT_W'(write_step);
  end

  // request capture and walk bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action;
      slot_q <= buffer_slot;
      size_q <= size_bytes;
      off_q  <= offset_bytes;
      wr_q   <= is_write;
      cyc_q  <= compute_amount;
    end
    if (cmd.eval) begin
      pre_q    <= pre_next;
      remain_q <= lines_next;
      line_q   <= first_next;
      add_q    <= add_next;
    end
    if (cmd.check) begin
      status_q <= fin;
    end
    if (cmd.walk) begin
      remain_q <= remain_q - lrat_pkg::NLINE_W'(1);
      line_q   <= line_q + lrat_pkg::LINE_W'(1);
    end
    if (rd_v) begin
      age <= count - rdata;
    end
  end

  // line stamp memory
  always_ff @(posedge clk) begin
    if (cmd.walk && !walk_read) begin
      stamp_mem[addr] <= wcount;
    end
    if (cmd.walk && walk_read) begin
      rdata <= stamp_mem[addr];
    end
  end

  // slot sizes
  always_ff @(posedge clk) begin
    if (cmd.check && fin == lrat_pkg::ST_OK && act_q == lrat_pkg::ACT_ALLOCATE) begin
      slot_size[slot_q] <= size_q;
    end
  end

  // configuration, counter, live flags, read pipeline and largest ages
  always_ff @(posedge clk) begin
    if (rst) begin
      write_step <= lrat_pkg::STEP_W'(1);
      read_step  <= lrat_pkg::STEP_W'(1);
      count      <= '0;
      live       <= '0;
      rd_v       <= 1'b0;
      age_v      <= 1'b0;
      for (int i = 0; i < lrat_pkg::BUFFER_SLOTS; i++) begin
        slot_max[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrat_pkg::REG_WRITE_STEP: write_step <= cfg_wdata;
          lrat_pkg::REG_READ_STEP:  read_step  <= cfg_wdata;
          default: ;
        endcase
      end
      rd_v  <= cmd.walk && walk_read;
      age_v <= rd_v;
      if (cmd.check && fin == lrat_pkg::ST_OK) begin
        case (act_q)
          lrat_pkg::ACT_COMPUTE:  count <= sum[lrat_pkg::COUNT_W-1:0];
          lrat_pkg::ACT_FREE:     live[slot_q] <= 1'b0;
          lrat_pkg::ACT_ALLOCATE: live[slot_q] <= 1'b1;
          default: ;
        endcase
      end
      // write walk stamps after the step, read walk steps after the age
      if (cmd.walk && !walk_read) begin
        count <= wcount;
      end
      if (rd_v) begin
        count <= count + lrat_pkg::COUNT_W'(read_step);
      end
      if (age_v && (age > slot_max[slot_q])) begin
        slot_max[slot_q] <= age;
      end
    end
  end

  // result fields
  assign status    = status_q;
  assign max_age   = slot_max[slot_q];
  assign cycle_now = count;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for line_retention_age_tracker_unit: a queue-fed driver
// sends requests in random bursts, a predictor tracks the cycle count, line
// stamps and largest read ages, and a monitor checks every result in order
// across several write/read step settings
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [lrat_pkg::ACTION_W-1:0] act;
    logic [lrat_pkg::SLOT_W-1:0]   slot;
    logic [lrat_pkg::BYTES_W-1:0]  size;
    logic [lrat_pkg::BYTES_W-1:0]  offset;
    logic                          wr;
    logic [lrat_pkg::CYC_W-1:0]    cyc;
    logic                          drain;  // hold this request until the unit is empty
  } tracker_request_t;

  typedef struct packed {
    logic [lrat_pkg::STATUS_W-1:0] st;
    logic [lrat_pkg::COUNT_W-1:0]  age;
    logic [lrat_pkg::COUNT_W-1:0]  cyc_now;
  } tracker_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [lrat_pkg::ACTION_W-1:0]  action = lrat_pkg::ACT_QUERY;
  logic [lrat_pkg::SLOT_W-1:0]    buffer_slot = '0;
  logic [lrat_pkg::BYTES_W-1:0]   size_bytes = '0;
  logic [lrat_pkg::BYTES_W-1:0]   offset_bytes = '0;
  logic                           is_write = 1'b0;
  logic [lrat_pkg::CYC_W-1:0]     compute_amount = '0;
  logic                           cfg_we = 1'b0;
  logic [lrat_pkg::CFG_IDX_W-1:0] cfg_index = lrat_pkg::REG_WRITE_STEP;
  logic [lrat_pkg::STEP_W-1:0]    cfg_wdata = '0;
  logic                           done;
  logic [lrat_pkg::STATUS_W-1:0]  status;
  logic [lrat_pkg::COUNT_W-1:0]   max_age;
  logic [lrat_pkg::COUNT_W-1:0]   cycle_now;

  line_retention_age_tracker_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .buffer_slot(buffer_slot), .size_bytes(size_bytes),
    .offset_bytes(offset_bytes), .is_write(is_write),
    .compute_amount(compute_amount),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .max_age(max_age), .cycle_now(cycle_now)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // pending requests and results still owed by the unit
  tracker_request_t req_q[$];
  tracker_result_t  result_q[$];
  int               mismatch_cnt = 0;

  // predicted tracker state
  logic [lrat_pkg::COUNT_W-1:0] model_cycles = '0;
  logic                         model_live [lrat_pkg::BUFFER_SLOTS];
  logic [lrat_pkg::BYTES_W-1:0] model_size [lrat_pkg::BUFFER_SLOTS];
  logic [lrat_pkg::COUNT_W-1:0] model_stamp [lrat_pkg::STAMP_DEPTH];
  logic [lrat_pkg::COUNT_W-1:0] model_max_age [lrat_pkg::BUFFER_SLOTS];
  logic [lrat_pkg::STEP_W-1:0]  model_wr_step = 16'd1;
  logic [lrat_pkg::STEP_W-1:0]  model_rd_step = 16'd1;

  // slot table as the stimulus expects it to be once queued requests run
  logic               plan_live [lrat_pkg::BUFFER_SLOTS];
  int                 plan_size [lrat_pkg::BUFFER_SLOTS];

  function automatic bit count_has_room(logic [lrat_pkg::COUNT_W-1:0] add);
    return model_cycles <= (~64'd0 - add);
  endfunction

  // apply one request to the predicted state and return its result
  function automatic tracker_result_t track_request(tracker_request_t r);
    tracker_result_t res;
    int s;
    int nlines;
    int first;
    int last;
    logic [lrat_pkg::COUNT_W-1:0] step;
    logic [lrat_pkg::COUNT_W-1:0] age;
    s = r.slot;
    res.st = lrat_pkg::ST_OK;
    case (r.act)
      lrat_pkg::ACT_COMPUTE: begin
        if (count_has_room(64'(r.cyc))) model_cycles += 64'(r.cyc);
        else res.st = lrat_pkg::ST_OVERFLOW;
      end
      lrat_pkg::ACT_ALLOCATE: begin
        if (r.size == 0 ||
            int'(r.size) > lrat_pkg::LINES_PER_BUFFER * lrat_pkg::LINE_BYTES) begin
          res.st = lrat_pkg::ST_SIZE;
        end else begin
          nlines = (int'(r.size) + lrat_pkg::LINE_BYTES - 1) / lrat_pkg::LINE_BYTES;
          if (!count_has_room(64'(nlines) * 64'(model_wr_step))) begin
            res.st = lrat_pkg::ST_OVERFLOW;
          end else begin
            for (int i = 0; i < nlines; i++) begin
              model_cycles += 64'(model_wr_step);
              model_stamp[s * lrat_pkg::LINES_PER_BUFFER + i] = model_cycles;
            end
            model_live[s] = 1'b1;
            model_size[s] = r.size;
          end
        end
      end
      lrat_pkg::ACT_FREE: begin
        if (model_live[s]) model_live[s] = 1'b0;
        else res.st = lrat_pkg::ST_INVALID;
      end
      lrat_pkg::ACT_ACCESS: begin
        if (r.size == 0) begin
          res.st = lrat_pkg::ST_SIZE;
        end else if (!model_live[s] || int'(r.offset) > int'(model_size[s]) ||
                     int'(r.size) > int'(model_size[s]) - int'(r.offset)) begin
          res.st = lrat_pkg::ST_INVALID;
        end else begin
          first = int'(r.offset) / lrat_pkg::LINE_BYTES;
          last = (int'(r.offset) + int'(r.size) - 1) / lrat_pkg::LINE_BYTES;
          step = r.wr ? 64'(model_wr_step) : 64'(model_rd_step);
          if (!count_has_room(64'(last - first + 1) * step)) begin
            res.st = lrat_pkg::ST_OVERFLOW;
          end else begin
            for (int ln = first; ln <= last; ln++) begin
              if (r.wr) begin
                model_cycles += step;
                model_stamp[s * lrat_pkg::LINES_PER_BUFFER + ln] = model_cycles;
              end else begin
                age = model_cycles - model_stamp[s * lrat_pkg::LINES_PER_BUFFER + ln];
                if (age > model_max_age[s]) model_max_age[s] = age;
                model_cycles += step;
              end
            end
          end
        end
      end
      default: begin
        // query and unused action codes leave the state alone
      end
    endcase
    res.age = model_max_age[s];
    res.cyc_now = model_cycles;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 5);
    return $urandom_range(10, 40);
  endfunction

  // driver: one request per handshake, sent in bursts with gaps between
  tracker_request_t cur_req;
  int               gap_left = 0;
  int               burst_left = 1;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // request taken at this edge
      if (start && !busy) begin
        result_q.insert(result_q.size(), track_request(cur_req));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = pick_gap();
        end
      end
      // a request still waiting on busy stays on the ports
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() != 0 && (!req_q[0].drain || (!start && !busy))) begin
          cur_req = req_q.pop_front();
          start <= 1'b1;
          action <= cur_req.act;
          buffer_slot <= cur_req.slot;
          size_bytes <= cur_req.size;
          offset_bytes <= cur_req.offset;
          is_write <= cur_req.wr;
          compute_amount <= cur_req.cyc;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results arrive in request order
  tracker_result_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d age %0d cycle %0d",
                   status, max_age, cycle_now);
      end else begin
        want = result_q.pop_front();
        if (status !== want.st || max_age !== want.age || cycle_now !== want.cyc_now) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected status %0d age %0d cycle %0d, got %0d %0d %0d",
                     want.st, want.age, want.cyc_now, status, max_age, cycle_now);
        end
      end
    end
  end

  task automatic queue_request(input logic [lrat_pkg::ACTION_W-1:0] act, input int slot,
                               input int size, input int offset, input logic wr,
                               input logic [lrat_pkg::CYC_W-1:0] cyc, input logic drain);
    tracker_request_t r;
    r.act = act;
    r.slot = lrat_pkg::SLOT_W'(slot);
    r.size = lrat_pkg::BYTES_W'(size);
    r.offset = lrat_pkg::BYTES_W'(offset);
    r.wr = wr;
    r.cyc = cyc;
    r.drain = drain;
    req_q.insert(req_q.size(), r);
    if (act == lrat_pkg::ACT_ALLOCATE && size >= 1 &&
        size <= lrat_pkg::LINES_PER_BUFFER * lrat_pkg::LINE_BYTES) begin
      plan_live[slot] = 1'b1;
      plan_size[slot] = size;
    end else if (act == lrat_pkg::ACT_FREE) begin
      plan_live[slot] = 1'b0;
    end
  endtask

  // mostly well-formed requests on live slots, with some noise
  task automatic queue_random_phase(input int n);
    int drain_at;
    int k;
    int s;
    int z;
    int off;
    int sz;
    int live_slots[$];
    logic [lrat_pkg::ACTION_W-1:0] act;
    logic [lrat_pkg::CYC_W-1:0] cyc;
    drain_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      live_slots.delete();
      for (int j = 0; j < lrat_pkg::BUFFER_SLOTS; j++)
        if (plan_live[j]) live_slots.insert(live_slots.size(), j);
      k = $urandom_range(0, 99);
      s = $urandom_range(0, lrat_pkg::BUFFER_SLOTS - 1);
      sz = $urandom_range(0, 8191);
      off = $urandom_range(0, 8191);
      cyc = $urandom;
      if (k < 14) begin
        act = lrat_pkg::ACT_ALLOCATE;
        k = $urandom_range(0, 19);
        if (k < 2) sz = (k == 0) ? 0 : $urandom_range(4097, 8191);
        else if (k < 5) sz = lrat_pkg::LINES_PER_BUFFER * lrat_pkg::LINE_BYTES;
        else sz = $urandom_range(1, lrat_pkg::LINES_PER_BUFFER * lrat_pkg::LINE_BYTES);
      end else if (k < 22) begin
        act = lrat_pkg::ACT_FREE;
        if (live_slots.size() != 0 && $urandom_range(0, 4) != 0)
          s = live_slots[$urandom_range(0, live_slots.size() - 1)];
      end else if (k < 70) begin
        act = lrat_pkg::ACT_ACCESS;
        if (live_slots.size() != 0 && $urandom_range(0, 99) < 85) begin
          s = live_slots[$urandom_range(0, live_slots.size() - 1)];
          z = plan_size[s];
          k = $urandom_range(0, 9);
          if (k == 0) begin
            // just past the end of the buffer
            off = z;
            sz = 1;
          end else if (k == 1) begin
            off = $urandom_range(0, z - 1);
            sz = z - off + 1;
          end else begin
            off = $urandom_range(0, z - 1);
            sz = (k < 4) ? z - off : $urandom_range(1, z - off);
          end
        end else if ($urandom_range(0, 4) == 0) begin
          sz = 0;
        end
      end else if (k < 82) begin
        act = lrat_pkg::ACT_COMPUTE;
        if ($urandom_range(0, 2) == 0) cyc = $urandom_range(0, 300);
      end else if (k < 96) begin
        act = lrat_pkg::ACT_QUERY;
      end else begin
        act = lrat_pkg::ACT_ALLOCATE + lrat_pkg::ACTION_W'($urandom_range(5, 7));
      end
      queue_request(act, s, sz, off, $urandom_range(0, 1), cyc, i == drain_at);
    end
  endtask

  // unit drained and no request in flight
  task automatic wait_quiet();
    do @(negedge clk);
    while (req_q.size() != 0 || result_q.size() != 0 || start || busy);
  endtask

  task automatic write_step(input logic [lrat_pkg::CFG_IDX_W-1:0] idx,
                            input logic [lrat_pkg::STEP_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == lrat_pkg::REG_WRITE_STEP) model_wr_step = val;
    else model_rd_step = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  logic [lrat_pkg::STEP_W-1:0] wr_settings [5];
  logic [lrat_pkg::STEP_W-1:0] rd_settings [5];

  initial begin
    foreach (model_live[i]) begin
      model_live[i] = 1'b0;
      model_size[i] = '0;
      model_max_age[i] = '0;
      plan_live[i] = 1'b0;
      plan_size[i] = 0;
    end
    foreach (model_stamp[i]) model_stamp[i] = '0;
    wr_settings = '{16'd0, 16'hFFFF, 16'hFFFF, 16'($urandom), 16'd1};
    rd_settings = '{16'd0, 16'hFFFF, 16'd0, 16'($urandom), 16'($urandom)};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed requests at the reset step costs
    queue_request(lrat_pkg::ACT_QUERY, 0, 0, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_FREE, 3, 0, 0, 1'b0, '0, 1'b0);        // free of a dead slot
    queue_request(lrat_pkg::ACT_ACCESS, 3, 0, 0, 1'b0, '0, 1'b0);      // zero size before dead slot
    queue_request(lrat_pkg::ACT_ACCESS, 3, 1, 0, 1'b1, '0, 1'b0);      // dead slot
    queue_request(lrat_pkg::ACT_ALLOCATE, 5, 0, 0, 1'b0, '0, 1'b0);    // zero size
    queue_request(lrat_pkg::ACT_ALLOCATE, 5, 4097, 0, 1'b0, '0, 1'b0); // one byte too large
    queue_request(lrat_pkg::ACT_ALLOCATE, 5, 8191, 8191, 1'b1, '1, 1'b0);
    queue_request(lrat_pkg::ACT_ALLOCATE, 0, 4096, 0, 1'b0, '0, 1'b0); // full buffer
    queue_request(lrat_pkg::ACT_ALLOCATE, 15, 1, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_COMPUTE, 0, 0, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_COMPUTE, 0, 0, 0, 1'b0, '1, 1'b0);
    queue_request(lrat_pkg::ACT_ACCESS, 0, 4096, 0, 1'b0, '0, 1'b0);   // read every line
    queue_request(lrat_pkg::ACT_ACCESS, 0, 1, 4095, 1'b1, '0, 1'b0);   // last byte
    queue_request(lrat_pkg::ACT_ACCESS, 0, 2, 63, 1'b1, '0, 1'b0);     // straddles two lines
    queue_request(lrat_pkg::ACT_ACCESS, 0, 1, 4096, 1'b0, '0, 1'b0);   // offset at the end
    queue_request(lrat_pkg::ACT_ACCESS, 0, 8191, 8191, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_ACCESS, 0, 4097, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_ACCESS, 15, 1, 1, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_ACCESS, 15, 1, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_ALLOCATE, 0, 100, 0, 1'b0, '0, 1'b0);  // realloc keeps largest age
    queue_request(lrat_pkg::ACT_ACCESS, 0, 100, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_QUERY, 0, 0, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_FREE, 15, 0, 0, 1'b0, '0, 1'b0);
    queue_request(lrat_pkg::ACT_QUERY, 15, 0, 0, 1'b0, '0, 1'b0);      // age survives free
    queue_request(lrat_pkg::ACT_FREE, 15, 0, 0, 1'b0, '0, 1'b0);
    for (int a = 5; a <= 7; a++)
      queue_request(lrat_pkg::ACTION_W'(a), $urandom_range(0, 15), $urandom_range(0, 8191),
                    $urandom_range(0, 8191), $urandom_range(0, 1), $urandom, 1'b0);

    // random phases, step costs changed only while the unit is empty
    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      write_step(lrat_pkg::REG_WRITE_STEP, wr_settings[p]);
      write_step(lrat_pkg::REG_READ_STEP, rd_settings[p]);
      @(negedge clk);
      queue_random_phase(90);
    end

    wait_quiet();
    repeat (80) @(posedge clk);
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
